>>> sv/bda_pkg.sv
// bda_pkg: shared types and constants for the binary to decimal ascii converter
package bda_pkg;

  localparam int VALUE_BITS = 64;
  localparam int COUNT_BITS = 5;
  localparam int CHAR_BITS  = 8;

  localparam logic [CHAR_BITS-1:0] ASCII_MINUS   = 8'h2D;
  // '0' & 0xF0: high nibble of every digit character
  localparam logic [3:0]           ASCII_DIGIT_HI = 4'h3;
  localparam logic [3:0]           BCD_ADJ_MIN    = 4'd5;
  localparam logic [3:0]           BCD_ADJ_ADD    = 4'd3;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0]        digit_count;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_out;
    logic                 last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;      // capture a new item
    logic shift;     // one double-dabble step
    logic dec;       // step digits_left down
    logic sel_sign;  // present the minus sign
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_last;   // final double-dabble step this cycle
    logic skip_more;   // leading zero may be dropped
    logic negative;
    logic last_digit;  // digits_left is one
  } ctrl_sts_t;

endpackage

>>> sv/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: signed binary to ascii decimal converter, top level
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_item_t  {value, digit_count}
//   out      output     out_valid / out_ready out_item_t {char_out, last}
//
// one item at a time: accept, then VALUE_WIDTH double-dabble steps,
// then dropping up to MAX_DIGITS-1 leading zeros (minimal mode only),
// then choose sign or digits; one character per cycle while out_ready is high
// in_ready is high only while idle; a stalled out_ready holds the current
// character and its last flag
// rst is synchronous, active high, and returns the block to idle
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int MAX_DIGITS  = 20,
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencing: idle, convert, drop zeros, sign, digits
  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // magnitude shifter, bcd register and character select
  bda_dpath #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> sv/bda_ctrl.sv
// bda_ctrl: sequencing state machine for the converter
module bda_ctrl
  import bda_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.skip_more) begin
          cmd.dec = 1'b1;
        end else if (sts.negative) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
        if (out_ready) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.dec = 1'b1;
          if (sts.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/bda_dpath.sv
// bda_dpath: magnitude, double-dabble bcd register and character select
module bda_dpath
  import bda_pkg::*;
#(
  parameter int MAX_DIGITS  = 20,
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output out_item_t out_data
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DL_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [DL_W-1:0]  MD_DL  = DL_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] VW_CNT = CNT_W'(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] magnitude;
  logic [BCD_W-1:0]       bcd;
  logic [CNT_W-1:0]       bit_cnt;
  logic [DL_W-1:0]        digits_left;
  logic                   negative_flag;
  logic                   minimal_mode;

  logic [VALUE_WIDTH-1:0] raw_val;
  logic [BCD_W-1:0]       bcd_adj;
  logic [DL_W-1:0]        dl_minus1;
  logic [IDX_W-1:0]       cur_idx;
  logic [3:0]             cur_digit;

  assign raw_val = in_data.value[VALUE_WIDTH-1:0];

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude     <= '0;
      digits_left   <= '0;
      negative_flag <= 1'b0;
      minimal_mode  <= 1'b0;
      bit_cnt       <= '0;
    end else begin
      if (cmd.load) begin
        negative_flag <= raw_val[VALUE_WIDTH-1];
        // most negative value negates to itself, which is 2^(w-1) unsigned
        magnitude     <= raw_val[VALUE_WIDTH-1] ? (~raw_val + 1'b1) : raw_val;
        bit_cnt       <= VW_CNT;
        minimal_mode  <= (in_data.digit_count == '0);
        if (in_data.digit_count == '0 || 32'(in_data.digit_count) > MAX_DIGITS) begin
          digits_left <= MD_DL;
        end else begin
          digits_left <= DL_W'(in_data.digit_count);
        end
      end else begin
        if (cmd.shift) begin
          magnitude <= {magnitude[VALUE_WIDTH-2:0], 1'b0};
          bit_cnt   <= bit_cnt - 1'b1;
        end
        if (cmd.dec) begin
          digits_left <= digits_left - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bcd <= '0;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], magnitude[VALUE_WIDTH-1]};
    end
  end

  assign dl_minus1 = digits_left - 1'b1;
  assign cur_idx   = dl_minus1[IDX_W-1:0];

  always_comb begin
    cur_digit = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (cur_idx == IDX_W'(i)) begin
        cur_digit = bcd[4*i +: 4];
      end
    end
  end

  assign sts.conv_last  = (bit_cnt == CNT_W'(1));
  assign sts.skip_more  = minimal_mode && (digits_left > DL_W'(1)) && (cur_digit == '0);
  assign sts.negative   = negative_flag;
  assign sts.last_digit = (digits_left == DL_W'(1));

  assign out_data.char_out = cmd.sel_sign ? ASCII_MINUS : {ASCII_DIGIT_HI, cur_digit};
  assign out_data.last     = !cmd.sel_sign && sts.last_digit;

endmodule

>>> sv/bda_checker.sv
// bda_checker: port-level checks for the converter, bound to the top level
module bda_checker
  import bda_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled item holds
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out item changed while stalled");

  // busy right after an item is taken, and nothing shown in that cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("accept did not start conversion");

  // no new item taken while characters are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while emitting");

  // nothing follows the last character
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last |=> !out_valid && in_ready)
    else $error("item emitted after last");

  // last only on digit characters
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.char_out != ASCII_MINUS)
    else $error("sign flagged as last");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
